FILE: rtl/fct_pkg.sv
// Package: shared types and constants for the frustum cull test block.
package fct_pkg;

    // Default number of clip planes held by the block
    localparam int NUM_PLANES_DEF = 6;

    // Field widths
    localparam int COEF_W   = 32;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int IDX_W    = 3;

    // Multiplier operands are 33-bit signed so |coef| and radius fit
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    // Accumulator: three products plus up to three cube terms plus offsets
    localparam int ACC_W  = 67;

    // Step counter: last step index per plane for each test kind
    localparam int          STEP_W          = 3;
    localparam logic [2:0]  STEP_LAST_BASIC = 3'd3;
    localparam logic [2:0]  STEP_LAST_CUBE  = 3'd6;

    // Item kinds
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_POINT  = 2'd1,
        ACT_CUBE   = 2'd2,
        ACT_SPHERE = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/frustum_cull_test.sv
// Frustum cull test: six-plane point, cube and sphere visibility check.
// A load is taken while idle and gives no result. Per plane, a test adds a*x, b*y
// and c*z to the offset term, a cube test also |a|r, |b|r and |c|r, then checks
// the sign; the walk stops at the first plane that culls the object. One shared
// 33x33 multiplier forms all products. The next item is taken in the cycle after
// the result transfers. Reset (aresetn, synchronous) clears all planes to zero.
module frustum_cull_test
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [IDX_W-1:0]           s_plane_index,
    input  logic signed [COEF_W-1:0]   s_coef_a,
    input  logic signed [COEF_W-1:0]   s_coef_b,
    input  logic signed [COEF_W-1:0]   s_coef_c,
    input  logic signed [COEF_W-1:0]   s_coef_d,
    input  logic signed [COORD_W-1:0]  s_center_x,
    input  logic signed [COORD_W-1:0]  s_center_y,
    input  logic signed [COORD_W-1:0]  s_center_z,
    input  logic [RADIUS_W-1:0]        s_radius,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_visible
);

    localparam int PCNT_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    // Plane storage
    logic [COEF_W-1:0] plane_a_reg [NUM_PLANES];
    logic [COEF_W-1:0] plane_b_reg [NUM_PLANES];
    logic [COEF_W-1:0] plane_c_reg [NUM_PLANES];
    logic [COEF_W-1:0] plane_d_reg [NUM_PLANES];

    // Sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [PCNT_W-1:0]      plane_cnt_reg, plane_cnt_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   visible_reg, visible_next;
    action_t                action_reg;
    logic [COORD_W-1:0]     x_reg, y_reg, z_reg;
    logic [RADIUS_W-1:0]    radius_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                   s_fire;
    logic [COEF_W-1:0]      pa, pb, pc, pd;
    logic [MUL_W-1:0]       abs_a, abs_b, abs_c, r_ext;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] acc_init, acc_sum;
    logic [STEP_W-1:0]      step_last;
    logic                   last_plane;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_DONE);
    assign m_visible = visible_reg;

    // Current plane and operand forms
    assign pa = plane_a_reg[plane_cnt_reg];
    assign pb = plane_b_reg[plane_cnt_reg];
    assign pc = plane_c_reg[plane_cnt_reg];
    assign pd = plane_d_reg[plane_cnt_reg];

    assign abs_a = pa[COEF_W-1] ? (MUL_W'(0) - {pa[COEF_W-1], pa}) : {1'b0, pa};
    assign abs_b = pb[COEF_W-1] ? (MUL_W'(0) - {pb[COEF_W-1], pb}) : {1'b0, pb};
    assign abs_c = pc[COEF_W-1] ? (MUL_W'(0) - {pc[COEF_W-1], pc}) : {1'b0, pc};
    assign r_ext = {2'b00, radius_reg};

    // Shared multiplier operand select by step
    always_comb begin
        unique case (step_reg)
            3'd0: begin mul_a = {pa[COEF_W-1], pa}; mul_b = {x_reg[COORD_W-1], x_reg}; end
            3'd1: begin mul_a = {pb[COEF_W-1], pb}; mul_b = {y_reg[COORD_W-1], y_reg}; end
            3'd2: begin mul_a = {pc[COEF_W-1], pc}; mul_b = {z_reg[COORD_W-1], z_reg}; end
            3'd3: begin mul_a = abs_a; mul_b = r_ext; end
            3'd4: begin mul_a = abs_b; mul_b = r_ext; end
            3'd5: begin mul_a = abs_c; mul_b = r_ext; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Offset term d*2^16, plus r*2^16 for a sphere
    always_comb begin
        acc_init = {{(ACC_W-COEF_W-16){pd[COEF_W-1]}}, pd, 16'h0000};
        if (action_reg == ACT_SPHERE) begin
            acc_init = acc_init + {{(ACC_W-RADIUS_W-16){1'b0}}, radius_reg, 16'h0000};
        end
    end

    assign acc_sum    = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign step_last  = (action_reg == ACT_CUBE) ? STEP_LAST_CUBE : STEP_LAST_BASIC;
    assign last_plane = (plane_cnt_reg == PCNT_W'(NUM_PLANES - 1));

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        plane_cnt_next = plane_cnt_reg;
        step_next      = step_reg;
        visible_next   = visible_reg;
        acc_next       = acc_reg;
        prod_next      = PROD_W'(mul_a * mul_b);
        unique case (state_reg)
            ST_IDLE: begin
                plane_cnt_next = '0;
                step_next      = '0;
                if (s_fire && (s_action != ACT_LOAD)) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (step_reg == 3'd0) begin
                    acc_next  = acc_init;
                    step_next = step_reg + 3'd1;
                end else if (step_reg != step_last) begin
                    acc_next  = acc_sum;
                    step_next = step_reg + 3'd1;
                end else begin
                    // plane done: cull on negative value
                    acc_next  = acc_sum;
                    step_next = '0;
                    if (acc_sum[ACC_W-1]) begin
                        visible_next = 1'b0;
                        state_next   = ST_DONE;
                    end else if (last_plane) begin
                        visible_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        plane_cnt_next = plane_cnt_reg + PCNT_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            plane_cnt_reg <= '0;
            step_reg      <= '0;
            visible_reg   <= 1'b1;
        end else begin
            state_reg     <= state_next;
            plane_cnt_reg <= plane_cnt_next;
            step_reg      <= step_next;
            visible_reg   <= visible_next;
        end
    end

    // Datapath registers and latched test operands
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (s_fire) begin
            action_reg <= action_t'(s_action);
            x_reg      <= s_center_x;
            y_reg      <= s_center_y;
            z_reg      <= s_center_z;
            radius_reg <= s_radius;
        end
    end

    // Plane load; out-of-range index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                plane_a_reg[i] <= '0;
                plane_b_reg[i] <= '0;
                plane_c_reg[i] <= '0;
                plane_d_reg[i] <= '0;
            end
        end else if (s_fire && (s_action == ACT_LOAD)) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                if (32'(s_plane_index) == i) begin
                    plane_a_reg[i] <= s_coef_a;
                    plane_b_reg[i] <= s_coef_b;
                    plane_c_reg[i] <= s_coef_c;
                    plane_d_reg[i] <= s_coef_d;
                end
            end
        end
    end

endmodule

FILE: test/tb.sv
// Self-checking testbench for frustum_cull_test: plane loads and point, cube and sphere tests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fct_pkg::*;

    localparam int          PLANES       = NUM_PLANES_DEF;
    localparam int          ONE          = 65536;          // 1.0 in Q16.16
    localparam int          BOX_EXTENT   = 1 << 20;        // half-width of the box frustum
    localparam int unsigned ITEMS_TARGET = 1450;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int          TAIL_CYCLES  = 60;
    localparam logic signed [31:0] MIN32 = 32'h8000_0000;
    localparam logic signed [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [RADIUS_W-1:0] RMAX = '1;

    typedef enum {STYLE_BOX, STYLE_TILTED, STYLE_WILD} plane_style_t;

    typedef struct {
        action_t                    action;
        logic [IDX_W-1:0]           plane_index;
        logic signed [COEF_W-1:0]   coef_a, coef_b, coef_c, coef_d;
        logic signed [COORD_W-1:0]  center_x, center_y, center_z;
        logic [RADIUS_W-1:0]        radius;
    } cull_item_t;

    // Plane store mirror plus the queue of visible flags still owed by the block
    class frustum_scoreboard;
        logic signed [COEF_W-1:0] plane_a [PLANES];
        logic signed [COEF_W-1:0] plane_b [PLANES];
        logic signed [COEF_W-1:0] plane_c [PLANES];
        logic signed [COEF_W-1:0] plane_d [PLANES];
        bit          visible_due [$];
        int unsigned mismatch_count;

        function new();
            for (int i = 0; i < PLANES; i++) begin
                plane_a[i] = '0;
                plane_b[i] = '0;
                plane_c[i] = '0;
                plane_d[i] = '0;
            end
            mismatch_count = 0;
        endfunction

        // Exact plane values in Q32.32; any plane with a negative value culls
        function bit predict_visible(cull_item_t it);
            logic signed [127:0] acc, ca, cb, cc, span, rad;
            rad = it.radius;
            for (int i = 0; i < PLANES; i++) begin
                ca  = plane_a[i];
                cb  = plane_b[i];
                cc  = plane_c[i];
                acc = ca * it.center_x + cb * it.center_y + cc * it.center_z
                    + plane_d[i] * ONE;
                if (it.action == ACT_CUBE) begin
                    // nearest corner lies radius*(|a|+|b|+|c|) further along the normal
                    span = (ca < 0 ? -ca : ca) + (cb < 0 ? -cb : cb) + (cc < 0 ? -cc : cc);
                    acc  = acc + span * rad;
                end else if (it.action == ACT_SPHERE) begin
                    acc = acc + rad * ONE;
                end
                if (acc < 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_transfer(cull_item_t it);
            if (it.action == ACT_LOAD) begin
                // out-of-range index leaves the store untouched
                if (it.plane_index < PLANES) begin
                    plane_a[it.plane_index] = it.coef_a;
                    plane_b[it.plane_index] = it.coef_b;
                    plane_c[it.plane_index] = it.coef_c;
                    plane_d[it.plane_index] = it.coef_d;
                end
            end else begin
                visible_due.push_back(predict_visible(it));
            end
        endfunction

        function void check_visible(logic seen);
            bit want;
            if (visible_due.size() == 0) begin
                $display("%0t: visible=%b transferred with nothing expected", $time, seen);
                mismatch_count++;
                return;
            end
            want = visible_due.pop_front();
            if (seen !== want) begin
                $display("%0t: visible mismatch, expected %b, actual %b", $time, want, seen);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return visible_due.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn       = 1'b0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_action      = '0;
    logic [IDX_W-1:0]           s_plane_index = '0;
    logic signed [COEF_W-1:0]   s_coef_a      = '0;
    logic signed [COEF_W-1:0]   s_coef_b      = '0;
    logic signed [COEF_W-1:0]   s_coef_c      = '0;
    logic signed [COEF_W-1:0]   s_coef_d      = '0;
    logic signed [COORD_W-1:0]  s_center_x    = '0;
    logic signed [COORD_W-1:0]  s_center_y    = '0;
    logic signed [COORD_W-1:0]  s_center_z    = '0;
    logic [RADIUS_W-1:0]        s_radius      = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic                       m_visible;

    frustum_scoreboard sb = new();
    int          burst_left   = 0;
    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    int          stall_mode   = 0;
    int          mode_left    = 0;

    frustum_cull_test uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_plane_index (s_plane_index),
        .s_coef_a      (s_coef_a),
        .s_coef_b      (s_coef_b),
        .s_coef_c      (s_coef_c),
        .s_coef_d      (s_coef_d),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_center_z    (s_center_z),
        .s_radius      (s_radius),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_visible     (m_visible)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: runs of always-ready, coin-flip and mostly-stalled
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watch both channels; every transfer feeds the scoreboard
    always @(posedge aclk) begin : channel_monitor
        cull_item_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.action      = action_t'(s_action);
                seen.plane_index = s_plane_index;
                seen.coef_a      = s_coef_a;
                seen.coef_b      = s_coef_b;
                seen.coef_c      = s_coef_c;
                seen.coef_d      = s_coef_d;
                seen.center_x    = s_center_x;
                seen.center_y    = s_center_y;
                seen.center_z    = s_center_z;
                seen.radius      = s_radius;
                sb.note_transfer(seen);
            end
            if (m_valid && m_ready)
                sb.check_visible(m_visible);
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] spread(int unsigned lim);
        int v;
        v = int'($urandom_range(0, 2 * lim)) - int'(lim);
        return v;
    endfunction

    // Send one item; bursts of random length with random gaps between them
    task automatic push_item(cull_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_action      <= it.action;
        s_plane_index <= it.plane_index;
        s_coef_a      <= it.coef_a;
        s_coef_b      <= it.coef_b;
        s_coef_c      <= it.coef_c;
        s_coef_d      <= it.coef_d;
        s_center_x    <= it.center_x;
        s_center_y    <= it.center_y;
        s_center_z    <= it.center_z;
        s_radius      <= it.radius;
        do @(posedge aclk); while (!s_ready);
        if (!(it.action == ACT_LOAD && it.plane_index >= PLANES))
            items_sent++;
    endtask

    task automatic load_plane(int idx, logic signed [31:0] a, b, c, d);
        cull_item_t it;
        it.action      = ACT_LOAD;
        it.plane_index = IDX_W'(idx);
        it.coef_a      = a;
        it.coef_b      = b;
        it.coef_c      = c;
        it.coef_d      = d;
        it.center_x    = $urandom;
        it.center_y    = $urandom;
        it.center_z    = $urandom;
        it.radius      = RADIUS_W'($urandom);
        push_item(it);
    endtask

    task automatic test_object(action_t act, logic signed [31:0] x, y, z,
                               logic [RADIUS_W-1:0] r);
        cull_item_t it;
        it.action      = act;
        it.plane_index = IDX_W'($urandom_range(0, 7));
        it.coef_a      = $urandom;
        it.coef_b      = $urandom;
        it.coef_c      = $urandom;
        it.coef_d      = $urandom;
        it.center_x    = x;
        it.center_y    = y;
        it.center_z    = z;
        it.radius      = r;
        push_item(it);
    endtask

    task automatic push_noise();
        cull_item_t it;
        it.action      = action_t'($urandom_range(0, 3));
        it.plane_index = IDX_W'($urandom_range(0, 7));
        it.coef_a      = $urandom;
        it.coef_b      = $urandom;
        it.coef_c      = $urandom;
        it.coef_d      = $urandom;
        it.center_x    = $urandom;
        it.center_y    = $urandom;
        it.center_z    = $urandom;
        it.radius      = RADIUS_W'($urandom);
        push_item(it);
    endtask

    // Hold off the sender until every owed result has transferred
    task automatic drain_results();
        s_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Box style: plane i faces inward on axis i/2, slightly tilted; other styles draw random planes
    task automatic make_plane(plane_style_t style, int i,
                              output logic signed [31:0] a, b, c, d);
        logic signed [31:0] n [3];
        case (style)
            STYLE_BOX: begin
                for (int k = 0; k < 3; k++)
                    n[k] = spread(4096);
                n[i / 2] = ((i % 2) ? -ONE : ONE) + spread(2048);
                d = BOX_EXTENT + spread(BOX_EXTENT / 8);
            end
            STYLE_TILTED: begin
                for (int k = 0; k < 3; k++)
                    n[k] = spread(ONE);
                d = spread(1 << 21);
            end
            default: begin
                for (int k = 0; k < 3; k++)
                    n[k] = $urandom;
                d = $urandom;
            end
        endcase
        a = n[0];
        b = n[1];
        c = n[2];
    endtask

    function automatic logic signed [31:0] pick_coord(plane_style_t style);
        if (style == STYLE_WILD || $urandom_range(0, 15) == 0)
            return $urandom;
        if (style == STYLE_BOX)
            return spread(BOX_EXTENT * 3 / 2);
        return spread(1 << 21);
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius(plane_style_t style);
        if ($urandom_range(0, 7) == 0)
            return '0;
        if (style == STYLE_WILD)
            return RADIUS_W'($urandom);
        if (style == STYLE_BOX)
            return RADIUS_W'($urandom_range(0, BOX_EXTENT / 2));
        return RADIUS_W'($urandom_range(0, 1 << 20));
    endfunction

    initial begin : stimulus
        plane_style_t       style;
        int                 roll, first, nloads, idx;
        logic signed [31:0] a, b, c, d;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Cleared planes: everything is visible, even at the range limits
        test_object(ACT_POINT, MIN32, MAX32, MIN32, '0);
        test_object(ACT_CUBE, MAX32, MIN32, MAX32, RMAX);
        test_object(ACT_SPHERE, MIN32, MIN32, MAX32, RMAX);
        // One plane x >= 0: touching counts as visible, one LSB behind is culled
        load_plane(0, ONE, 0, 0, 0);
        test_object(ACT_POINT, 0, 0, 0, '0);
        test_object(ACT_POINT, -1, 0, 0, '0);
        test_object(ACT_SPHERE, -ONE, 0, 0, ONE);
        test_object(ACT_SPHERE, -ONE - 1, 0, 0, ONE);
        test_object(ACT_CUBE, -ONE, 5 * ONE, -7 * ONE, ONE);
        test_object(ACT_CUBE, -ONE - 1, 0, 0, ONE);
        // Loads past the last plane are dropped
        load_plane(6, -ONE, 0, 0, MIN32);
        load_plane(7, -ONE, 0, 0, MIN32);
        test_object(ACT_POINT, 0, 0, 0, '0);
        // Extreme coefficients against extreme coordinates
        load_plane(5, MIN32, MAX32, MIN32, MAX32);
        test_object(ACT_POINT, MAX32, MAX32, MIN32, '0);
        test_object(ACT_POINT, MIN32, MIN32, MAX32, '0);
        test_object(ACT_CUBE, MIN32, MIN32, MAX32, RMAX);
        test_object(ACT_SPHERE, MIN32, MIN32, MAX32, RMAX);
        load_plane(5, MAX32, MIN32, MAX32, MIN32);
        test_object(ACT_CUBE, MIN32, MAX32, MIN32, RMAX);
        test_object(ACT_SPHERE, MAX32, MAX32, MAX32, '0);
        load_plane(0, 0, 0, 0, 0);
        load_plane(5, 0, 0, 0, 0);
        drain_results();

        // Random frustums, each followed by a run of object tests
        while (items_sent < ITEMS_TARGET) begin
            roll  = $urandom_range(0, 9);
            style = (roll < 6) ? STYLE_BOX : (roll < 9) ? STYLE_TILTED : STYLE_WILD;
            first = $urandom_range(0, PLANES - 1);
            // now and then only part of the frustum is reloaded
            nloads = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PLANES - 1) : PLANES;
            for (int k = 0; k < nloads; k++) begin
                idx = (first + k) % PLANES;
                make_plane(style, idx, a, b, c, d);
                load_plane(idx, a, b, c, d);
                if ($urandom_range(0, 15) == 0)
                    load_plane($urandom_range(PLANES, 7), $urandom, $urandom, $urandom, $urandom);
            end
            repeat ($urandom_range(4, 30)) begin
                if ($urandom_range(0, 11) == 0)
                    push_noise();
                else
                    test_object(action_t'($urandom_range(1, 3)), pick_coord(style),
                                pick_coord(style), pick_coord(style), pick_radius(style));
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fct_pkg.sv
rtl/frustum_cull_test.sv
test/tb.sv
